[rtl/mm3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types and constants for the 3x3 min/max morphology core.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W  = 8;
    localparam int FW_W   = 11;
    localparam int FH_W   = 12;
    localparam int ROW_W  = FH_W + 1;
    localparam int CFG_DW = 12;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

    localparam logic [FW_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic MODE_ERODE = 1'b0;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // one transaction on its way from the controller to the line buffer and the window
    typedef struct packed {
        logic             act;
        logic             pix;
        logic [PIX_W-1:0] newv;
        logic             due;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        logic             eor;
        logic             eof;
    } mm3_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             eor;
        logic             eof;
    } mm3_result_t;

endpackage
`default_nettype wire

[rtl/mm3_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_ctrl
// Raster position tracking, flush bookkeeping and line buffer addressing.
// ----------------------------------------------------------------------------
module mm3_ctrl import mm3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = CW + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             kind,
    input  wire logic [PIX_W-1:0] pixel_value,
    input  wire logic             restart,
    input  wire logic [FW_W-1:0]  width_reg,
    input  wire logic [FH_W-1:0]  height_reg,
    output logic                  rd_en,
    output logic [CW-1:0]         rd_addr,
    output mm3_item_t             s1_item_reg,
    output logic [CW-1:0]         s1_addr_reg
);

    logic [CW-1:0]    in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [WW-1:0]    pend_reg, pend_next;
    logic [WW-1:0]    eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [ROW_W-1:0] h_ext;
    logic [CW-1:0]    ic, oc;
    logic [ROW_W-1:0] ir, orow, ir_inc, or_inc;
    logic [WW-1:0]    pend, ic_inc, oc_inc;
    logic             restart_pix, act, due, last_pix, in_wrap, out_wrap, eor;
    mm3_item_t        item;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        eff_h = (height_reg == '0) ? FH_W'(1) : height_reg;
        h_ext = {1'b0, eff_h};

        // a pixel arriving while flushes are owed starts a new frame
        restart_pix = (kind == KIND_PIXEL) && (pend_reg != '0);
        act         = in_fire && ((kind == KIND_PIXEL) || (pend_reg != '0));

        ic   = restart_pix ? '0 : in_col_reg;
        ir   = restart_pix ? '0 : in_row_reg;
        oc   = restart_pix ? '0 : out_col_reg;
        orow = restart_pix ? '0 : out_row_reg;
        pend = restart_pix ? '0 : pend_reg;

        ic_inc   = {1'b0, ic} + WW'(1);
        ir_inc   = ir + ROW_W'(1);
        in_wrap  = ic_inc >= eff_w;
        oc_inc   = {1'b0, oc} + WW'(1);
        or_inc   = orow + ROW_W'(1);
        out_wrap = oc_inc >= eff_w;
        eor      = oc_inc == eff_w;

        due      = (ir >= ROW_W'(2)) || ((ir == ROW_W'(1)) && (ic != '0));
        last_pix = (kind == KIND_PIXEL) && (ir_inc == h_ext) && (ic_inc == eff_w);

        in_col_next = in_wrap ? '0 : ic_inc[CW-1:0];
        in_row_next = in_wrap ? ir_inc : ir;

        if (last_pix)
            pend_next = eff_w + WW'(1);
        else if (kind == KIND_FLUSH)
            pend_next = pend - WW'(1);
        else
            pend_next = pend;

        out_col_next = oc;
        out_row_next = orow;
        if (due)
        begin
            out_col_next = out_wrap ? '0 : oc_inc[CW-1:0];
            out_row_next = out_wrap ? or_inc : orow;
        end

        // last owed flush: back to the top of a frame
        if ((kind == KIND_FLUSH) && (pend_next == '0))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end

        item.act    = act;
        item.pix    = (kind == KIND_PIXEL);
        item.newv   = (kind == KIND_PIXEL) ? pixel_value : '0;
        item.due    = act && due;
        item.row_ok = {or_inc < h_ext, orow < h_ext, orow != '0};
        item.col_ok = {oc_inc < eff_w, {1'b0, oc} < eff_w, oc != '0};
        item.eor    = eor;
        item.eof    = eor && (or_inc == h_ext);

        rd_en   = act;
        rd_addr = ic;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            s1_item_reg <= '0;
        end
        else
        begin
            if (restart)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                pend_reg    <= '0;
            end
            else if (act)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
                pend_reg    <= pend_next;
            end
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= ic;
    end

endmodule
`default_nettype wire

[rtl/mm3_line_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_line_buf
// Two line buffers packed into one RAM word; read-modify-write per column.
// ----------------------------------------------------------------------------
module mm3_line_buf import mm3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [CW-1:0]    rd_addr,
    input  wire mm3_item_t        s1_item,
    input  wire logic [CW-1:0]    s1_addr,
    output logic [PIX_W-1:0]      up,
    output logic [PIX_W-1:0]      mid
);

    // word = {upper line, middle line}
    logic [2*PIX_W-1:0] line_ram [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_q_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_reg;
    logic [2*PIX_W-1:0] cur;
    logic [2*PIX_W-1:0] wr_data;
    logic               wr_en;

    always_comb
    begin
        cur     = fwd_reg ? fwd_data_reg : rd_q_reg;
        up      = cur[2*PIX_W-1:PIX_W];
        mid     = cur[PIX_W-1:0];
        // middle moves up, new pixel lands in middle
        wr_en   = s1_item.act && s1_item.pix;
        wr_data = {mid, s1_item.newv};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_ram[s1_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= line_ram[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // same column read while written (one-pixel rows): bypass the RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= wr_en && (rd_addr == s1_addr);
    end

endmodule
`default_nettype wire

[rtl/mm3_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_window
// 3x3 window shift registers and masked min/max reduction.
// ----------------------------------------------------------------------------
module mm3_window import mm3_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mm3_item_t        s1_item,
    input  wire logic [PIX_W-1:0] up,
    input  wire logic [PIX_W-1:0] mid,
    input  wire logic             mode,
    output logic                  res_valid,
    output mm3_result_t           res
);

    logic [PIX_W-1:0] win_reg [9];
    logic             s2_valid_reg;
    logic [8:0]       s2_mask_reg;
    logic             s2_eor_reg, s2_eof_reg;
    logic [PIX_W-1:0] m [9];
    logic [PIX_W-1:0] l1 [4];
    logic [PIX_W-1:0] l2 [2];
    logic [PIX_W-1:0] l3;
    logic [8:0]       mask;

    function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic             mx);
        if (mx)
            return (a > b) ? a : b;
        else
            return (a < b) ? a : b;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mask[i*3+k] = s1_item.row_ok[i] && s1_item.col_ok[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_item.act)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up;
                win_reg[5] <= mid;
                win_reg[8] <= s1_item.newv;
            end
            s2_valid_reg <= s1_item.due;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mask_reg <= mask;
        s2_eor_reg  <= s1_item.eor;
        s2_eof_reg  <= s1_item.eof;
    end

    // out-of-frame taps take the neutral value
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            m[i] = s2_mask_reg[i] ? win_reg[i] : ((mode == MODE_ERODE) ? PIX_MAX : '0);
        for (int i = 0; i < 4; i++)
            l1[i] = pick(m[2*i], m[2*i+1], mode);
        l2[0] = pick(l1[0], l1[1], mode);
        l2[1] = pick(l1[2], l1[3], mode);
        l3    = pick(l2[0], l2[1], mode);

        res_valid = s2_valid_reg;
        res.value = pick(l3, m[8], mode);
        res.eor   = s2_eor_reg;
        res.eof   = s2_eof_reg;
    end

endmodule
`default_nettype wire

[rtl/mm3_out_q.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_out_q
// Small result queue decoupling the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
module mm3_out_q import mm3_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire mm3_result_t  push_data,
    input  wire logic         pop,
    output logic              valid,
    output mm3_result_t       data,
    output logic [OQ_CW-1:0]  level
);

    mm3_result_t      fifo_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        valid    = cnt_reg != '0;
        data     = fifo_reg[rd_ptr_reg];
        level    = cnt_reg;
        cnt_next = cnt_reg + OQ_CW'(push) - OQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OQ_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OQ_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/morphology_3x3_min_max_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morphology_3x3_min_max_core
// 3x3 gray erosion/dilation on a raster pixel stream with two line buffers.
// ----------------------------------------------------------------------------
// Path: the input transaction that releases a result is accepted, then passes
//   the RAM read, the window update and the reduction into the queue.
// Throughput: one transaction per cycle while in_stall is low, set by the
//   single-port-per-side line RAM doing one read and one write each cycle.
// Reset: counters and pipeline cleared, mode = erosion, 640x480 frame;
//   line RAM is not cleared, no clearing pass, stream is ready at once.
// ----------------------------------------------------------------------------
module morphology_3x3_min_max_core import mm3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              kind,
    input  wire logic [PIX_W-1:0]  pixel_value,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [PIX_W-1:0]       result_value,
    output logic                   end_of_row,
    output logic                   end_of_frame,
    // configuration writes
    input  wire logic              cfg_write_en,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic             mode_reg;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic             restart;
    logic             in_fire;
    logic             rd_en;
    logic [CW-1:0]    rd_addr;
    mm3_item_t        s1_item;
    logic [CW-1:0]    s1_addr;
    logic [PIX_W-1:0] up, mid;
    logic             res_valid;
    mm3_result_t      res;
    mm3_result_t      q_data;
    logic [OQ_CW-1:0] q_level;
    logic [OQ_CW-1:0] committed;

    // ------------------------------------------------------------------
    // Configuration. A size write restarts the raster; a mode write just
    // changes the reduction from the next result on.
    // ------------------------------------------------------------------
    assign restart = cfg_write_en && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ERODE;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Every transaction that will produce a result owns a
    // queue slot from acceptance on: slots held in the queue plus results
    // still in the two pipeline stages. Stall only when all are spoken for,
    // so the pipeline itself never stops.
    // ------------------------------------------------------------------
    assign committed = q_level + OQ_CW'(s1_item.due) + OQ_CW'(res_valid);
    assign in_stall  = committed >= OQ_CW'(OQ_DEPTH);
    assign in_fire   = in_valid && !in_stall;

    // position counters, flush accounting, RAM read address
    mm3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .kind        (kind),
        .pixel_value (pixel_value),
        .restart     (restart),
        .width_reg   (width_reg),
        .height_reg  (height_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_item_reg (s1_item),
        .s1_addr_reg (s1_addr)
    );

    // read at acceptance, write back in the following cycle (bypass on same column)
    mm3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .s1_item (s1_item),
        .s1_addr (s1_addr),
        .up      (up),
        .mid     (mid)
    );

    // window shift, then clipped min/max over the 3x3 taps
    mm3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_item   (s1_item),
        .up        (up),
        .mid       (mid),
        .mode      (mode_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output skid queue
    mm3_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_valid && !out_stall),
        .valid     (out_valid),
        .data      (q_data),
        .level     (q_level)
    );

    assign result_value = q_data.value;
    assign end_of_row   = q_data.eor;
    assign end_of_frame = q_data.eof;

endmodule
`default_nettype wire

[rtl/mm3_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_checker
// Port-level checks for the morphology core, bound to the top level.
// ----------------------------------------------------------------------------
module mm3_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] result_value,
    input wire logic       end_of_row,
    input wire logic       end_of_frame
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(result_value) && $stable(end_of_row)
            && $stable(end_of_frame))
        else $error("stalled result changed");

    // last pixel of a frame is also last of its row
    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_row)
        else $error("end_of_frame without end_of_row");

    // an empty output side never back-pressures the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output queue");

    // a result first shows up only after an accepted transaction released it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
        else $error("result appeared without a matching input transaction");

endmodule

bind morphology_3x3_min_max_core mm3_checker u_mm3_checker (.*);
`default_nettype wire
